>>> rtl/pagb_pkg.sv
package pagb_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int MAX_SEED      = 8;
	localparam int FRAC_W        = 32;
	localparam int DEG_W         = 16;
	localparam int NODE_OUT_W    = 10;
	localparam int EDGE_NUM_W    = 14;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACH_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_NODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT     = 2'd2;

	localparam logic        ATTACH_MODE_RST    = 1'b0;
	localparam logic [3:0]  EDGES_PER_NODE_RST = 4'd2;
	localparam logic [10:0] NODE_COUNT_RST     = 11'd1024;

	// Input operation codes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_DRAW  = 1'b1;

	localparam logic [DEG_W-1:0] DEG_SAT = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEED,
		ST_RD_I,
		ST_MUL,
		ST_THR,
		ST_SCAN,
		ST_RD_J,
		ST_WR_I,
		ST_EMIT
	} pagb_state_t;

	typedef struct packed {
		logic accept;
		logic seed_init;
		logic clr_step;
		logic seed_emit;
		logic stop_build;
		logic rd_i;
		logic mul;
		logic thr;
		logic scan_step;
		logic rd_j;
		logic wr_i;
		logic draw_emit;
	} pagb_cmd_t;

	typedef struct packed {
		logic building;
		logic draw_go;
		logic clr_last;
		logic seed_none;
		logic seed_last;
		logic uniform;
		logic scan_hit;
		logic out_free;
	} pagb_status_t;

endpackage

>>> rtl/pagb_ctrl.sv
module pagb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  pagb_pkg::pagb_status_t status,
	output pagb_pkg::pagb_cmd_t    cmd
);

	pagb_pkg::pagb_state_t state_q;
	pagb_pkg::pagb_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pagb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			pagb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (op == pagb_pkg::OP_START) begin
						cmd.seed_init = 1'b1;
						state_nxt     = pagb_pkg::ST_CLEAR;
					end else if (status.building) begin
						if (status.draw_go) begin
							state_nxt = pagb_pkg::ST_RD_I;
						end else begin
							cmd.stop_build = 1'b1;
						end
					end
				end
			end
			pagb_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_nxt = status.seed_none ? pagb_pkg::ST_IDLE : pagb_pkg::ST_SEED;
				end
			end
			pagb_pkg::ST_SEED: begin
				if (status.out_free) begin
					cmd.seed_emit = 1'b1;
					if (status.seed_last) begin
						state_nxt = pagb_pkg::ST_IDLE;
					end
				end
			end
			pagb_pkg::ST_RD_I: begin
				cmd.rd_i  = 1'b1;
				state_nxt = pagb_pkg::ST_MUL;
			end
			pagb_pkg::ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = pagb_pkg::ST_THR;
			end
			pagb_pkg::ST_THR: begin
				cmd.thr   = 1'b1;
				state_nxt = status.uniform ? pagb_pkg::ST_RD_J : pagb_pkg::ST_SCAN;
			end
			pagb_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_hit) begin
					state_nxt = pagb_pkg::ST_RD_J;
				end
			end
			pagb_pkg::ST_RD_J: begin
				cmd.rd_j  = 1'b1;
				state_nxt = pagb_pkg::ST_WR_I;
			end
			pagb_pkg::ST_WR_I: begin
				cmd.wr_i  = 1'b1;
				state_nxt = pagb_pkg::ST_EMIT;
			end
			pagb_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.draw_emit = 1'b1;
					state_nxt     = pagb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pagb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/pagb_dpath.sv
module pagb_dpath #(
	parameter int MAX_NODES = pagb_pkg::MAX_NODES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [pagb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pagb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [pagb_pkg::FRAC_W-1:0]          rand_fraction,
	input  logic                                 out_ready,
	input  pagb_pkg::pagb_cmd_t                  cmd,
	output pagb_pkg::pagb_status_t               status,
	output logic                                 out_valid,
	output logic [pagb_pkg::NODE_OUT_W-1:0]      edge_source,
	output logic [pagb_pkg::NODE_OUT_W-1:0]      edge_target,
	output logic [pagb_pkg::EDGE_NUM_W-1:0]      edge_number,
	output logic                                 last_of_run,
	output logic                                 graph_done
);

	localparam int AW     = $clog2(MAX_NODES);
	localparam int NODE_W = $clog2(MAX_NODES + 1);
	localparam int SUM_W  = pagb_pkg::DEG_W + AW;
	localparam int PW     = pagb_pkg::FRAC_W + SUM_W;
	localparam int KCAP   = (MAX_NODES < pagb_pkg::MAX_SEED) ? MAX_NODES : pagb_pkg::MAX_SEED;
	localparam int CW     = (AW > 4) ? AW : 4;
	localparam int KNW    = (NODE_W > 4) ? NODE_W : 4;
	localparam int NCW    = (NODE_W > pagb_pkg::CFG_DATA_W) ? NODE_W : pagb_pkg::CFG_DATA_W;
	localparam int XW     = (AW > pagb_pkg::NODE_OUT_W) ? AW : pagb_pkg::NODE_OUT_W;
	localparam int DW     = pagb_pkg::DEG_W;

	// Configuration registers.
	logic        attach_mode_q;
	logic [3:0]  edges_per_node_q;
	logic [10:0] node_count_q;

	// Build state.
	logic [NODE_W-1:0]                  current_node_q;
	logic [2:0]                         edge_slot_q;
	logic [pagb_pkg::EDGE_NUM_W-1:0]    edge_counter_q;
	logic                               building_q;
	logic [SUM_W-1:0]                   sum_all_q;

	// Working registers.
	logic [pagb_pkg::FRAC_W-1:0] frac_q;
	logic [AW-1:0]               clr_addr_q;
	logic [2:0]                  seed_a_q;
	logic [2:0]                  seed_b_q;
	logic                        seed_phase_q;
	logic [DW-1:0]               deg_i_q;
	logic [DW-1:0]               deg_j_q;
	logic [PW-1:0]               prod_q;
	logic [SUM_W-1:0]            thr_q;
	logic [SUM_W-1:0]            cum_q;
	logic [AW-1:0]               scan_addr_q;
	logic [AW-1:0]               scan_idx_q;
	logic                        scan_vld_q;
	logic [AW-1:0]               j_q;

	// Degree table.
	logic [DW-1:0] mem [MAX_NODES];
	logic [DW-1:0] rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;

	// Output register.
	logic                               out_valid_q;
	logic [pagb_pkg::NODE_OUT_W-1:0]    out_src_q;
	logic [pagb_pkg::NODE_OUT_W-1:0]    out_tgt_q;
	logic [pagb_pkg::EDGE_NUM_W-1:0]    out_num_q;
	logic                               out_last_q;
	logic                               out_done_q;

	logic [3:0]          eff_k;
	logic [NODE_W-1:0]   eff_n;
	logic [NCW-1:0]      n_ext;
	logic [AW-1:0]       i_a;
	logic                n_le_k;
	logic                out_free;
	logic                seed_last;
	logic [SUM_W-1:0]    mul_b;
	logic [SUM_W-1:0]    ceil_v;
	logic [SUM_W-1:0]    cum_nxt;
	logic                scan_hit;
	logic [DW-1:0]       deg_i_inc;
	logic [DW-1:0]       deg_j_inc;
	logic [3:0]          slot_inc;
	logic                slot_wrap;
	logic [NODE_W-1:0]   node_inc;
	logic                draw_done;
	logic [XW-1:0]       i_x;
	logic [XW-1:0]       j_x;

	always_comb begin
		eff_k  = (edges_per_node_q > 4'(KCAP)) ? 4'(KCAP) : edges_per_node_q;
		n_ext  = NCW'(node_count_q);
		eff_n  = (n_ext > NCW'(MAX_NODES)) ? NODE_W'(MAX_NODES) : NODE_W'(n_ext);
		n_le_k = KNW'(eff_n) <= KNW'(eff_k);
		i_a    = current_node_q[AW-1:0];
		out_free = !out_valid_q || out_ready;
		seed_last = seed_phase_q && ({1'b0, seed_a_q} == eff_k - 4'd2)
			&& ({1'b0, seed_b_q} == eff_k - 4'd1);

		mul_b  = attach_mode_q ? SUM_W'(current_node_q) : (sum_all_q - SUM_W'(rdata_q));
		ceil_v = prod_q[PW-1:pagb_pkg::FRAC_W]
			+ SUM_W'(|prod_q[pagb_pkg::FRAC_W-1:0]);

		cum_nxt  = cum_q + SUM_W'(rdata_q);
		scan_hit = scan_vld_q && ((cum_nxt >= thr_q) || (scan_idx_q == i_a - AW'(1)));

		deg_i_inc = (deg_i_q == pagb_pkg::DEG_SAT) ? deg_i_q : deg_i_q + DW'(1);
		deg_j_inc = (deg_j_q == pagb_pkg::DEG_SAT) ? deg_j_q : deg_j_q + DW'(1);

		slot_inc  = {1'b0, edge_slot_q} + 4'd1;
		slot_wrap = slot_inc >= eff_k;
		node_inc  = current_node_q + NODE_W'(1);
		draw_done = slot_wrap && (node_inc >= eff_n);

		i_x = XW'(i_a);
		j_x = XW'(j_q);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = (CW'(clr_addr_q) < CW'(eff_k)) ? DW'(1) : '0;
		mem_raddr = i_a;
		if (cmd.clr_step) begin
			mem_we = 1'b1;
		end else if (cmd.wr_i) begin
			mem_we    = 1'b1;
			mem_waddr = i_a;
			mem_wdata = deg_i_inc;
		end else if (cmd.draw_emit) begin
			mem_we    = 1'b1;
			mem_waddr = j_q;
			mem_wdata = deg_j_inc;
		end
		if (cmd.rd_j) begin
			mem_raddr = j_q;
		end else if (cmd.scan_step) begin
			mem_raddr = scan_addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attach_mode_q    <= pagb_pkg::ATTACH_MODE_RST;
			edges_per_node_q <= pagb_pkg::EDGES_PER_NODE_RST;
			node_count_q     <= pagb_pkg::NODE_COUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				pagb_pkg::CFG_ATTACH_MODE:    attach_mode_q    <= cfg_data[0];
				pagb_pkg::CFG_EDGES_PER_NODE: edges_per_node_q <= cfg_data[3:0];
				pagb_pkg::CFG_NODE_COUNT:     node_count_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_node_q <= '0;
			edge_slot_q    <= '0;
			edge_counter_q <= '0;
			building_q     <= 1'b0;
			sum_all_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.seed_init) begin
				current_node_q <= NODE_W'(eff_k);
				edge_slot_q    <= '0;
				edge_counter_q <= '0;
				building_q     <= (eff_k != 4'd0) && !n_le_k;
				sum_all_q      <= SUM_W'(eff_k);
			end
			if (cmd.stop_build) begin
				building_q <= 1'b0;
			end
			if (cmd.seed_emit) begin
				edge_counter_q <= edge_counter_q + pagb_pkg::EDGE_NUM_W'(1);
			end
			if (cmd.draw_emit) begin
				edge_counter_q <= edge_counter_q + pagb_pkg::EDGE_NUM_W'(1);
				sum_all_q <= sum_all_q + SUM_W'(deg_i_q != pagb_pkg::DEG_SAT)
					+ SUM_W'(deg_j_q != pagb_pkg::DEG_SAT);
				if (slot_wrap) begin
					edge_slot_q    <= '0;
					current_node_q <= node_inc;
					if (node_inc >= eff_n) begin
						building_q <= 1'b0;
					end
				end else begin
					edge_slot_q <= slot_inc[2:0];
				end
			end
			if (cmd.seed_emit || cmd.draw_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			frac_q <= rand_fraction;
		end
		if (cmd.seed_init) begin
			clr_addr_q   <= '0;
			seed_a_q     <= 3'd0;
			seed_b_q     <= 3'd1;
			seed_phase_q <= 1'b0;
		end
		if (cmd.clr_step) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
		if (cmd.seed_emit) begin
			out_src_q  <= seed_phase_q ? pagb_pkg::NODE_OUT_W'(seed_a_q)
				: pagb_pkg::NODE_OUT_W'(seed_b_q);
			out_tgt_q  <= seed_phase_q ? pagb_pkg::NODE_OUT_W'(seed_b_q)
				: pagb_pkg::NODE_OUT_W'(seed_a_q);
			out_num_q  <= edge_counter_q;
			out_last_q <= seed_last;
			out_done_q <= seed_last && n_le_k;
			if (!seed_phase_q) begin
				seed_phase_q <= 1'b1;
			end else begin
				seed_phase_q <= 1'b0;
				if ({1'b0, seed_b_q} == eff_k - 4'd1) begin
					seed_a_q <= seed_a_q + 3'd1;
					seed_b_q <= seed_a_q + 3'd2;
				end else begin
					seed_b_q <= seed_b_q + 3'd1;
				end
			end
		end
		if (cmd.mul) begin
			deg_i_q <= rdata_q;
			prod_q  <= PW'(frac_q) * PW'(mul_b);
		end
		if (cmd.thr) begin
			thr_q       <= ceil_v;
			cum_q       <= '0;
			scan_addr_q <= '0;
			scan_vld_q  <= 1'b0;
			j_q         <= (ceil_v == '0) ? '0 : AW'(ceil_v - SUM_W'(1));
		end
		if (cmd.scan_step) begin
			scan_addr_q <= scan_addr_q + AW'(1);
			scan_idx_q  <= scan_addr_q;
			scan_vld_q  <= 1'b1;
			if (scan_vld_q) begin
				cum_q <= cum_nxt;
			end
			if (scan_hit) begin
				j_q <= scan_idx_q;
			end
		end
		if (cmd.wr_i) begin
			deg_j_q <= rdata_q;
		end
		if (cmd.draw_emit) begin
			out_src_q  <= deg_i_q[0] ? i_x[pagb_pkg::NODE_OUT_W-1:0]
				: j_x[pagb_pkg::NODE_OUT_W-1:0];
			out_tgt_q  <= deg_i_q[0] ? j_x[pagb_pkg::NODE_OUT_W-1:0]
				: i_x[pagb_pkg::NODE_OUT_W-1:0];
			out_num_q  <= edge_counter_q;
			out_last_q <= 1'b1;
			out_done_q <= draw_done;
		end
	end

	always_comb begin
		status.building  = building_q;
		status.draw_go   = building_q && (eff_k != 4'd0) && (current_node_q < eff_n);
		status.clr_last  = clr_addr_q == AW'(MAX_NODES - 1);
		status.seed_none = eff_k < 4'd2;
		status.seed_last = seed_last;
		status.uniform   = attach_mode_q;
		status.scan_hit  = scan_hit;
		status.out_free  = out_free;
	end

	assign out_valid   = out_valid_q;
	assign edge_source = out_src_q;
	assign edge_target = out_tgt_q;
	assign edge_number = out_num_q;
	assign last_of_run = out_last_q;
	assign graph_done  = out_done_q;

endmodule

>>> rtl/preferential_attachment_graph_builder.sv
// Preferential attachment graph builder. A start transaction (op = 0) clears the
// degree table in one sweep over all MAX_NODES entries, gives each of the K
// seed nodes degree 1 and then emits the K*(K-1) seed edges, one per cycle
// while the output side takes them. A draw transaction (op = 1) adds one edge
// joining the current new node i and a target among nodes 0..i-1, picked either in
// proportion to degree or uniformly, using rand_fraction as a 0.32 fraction.
// In a degree-weighted draw the degree of node i is read, the threshold is
// formed by one multiply, and a roulette scan then walks the degree table one
// entry per cycle through its single read port until the running sum reaches
// the threshold or the scan reaches node i-1. A uniform draw skips the scan.
// Draws that arrive while no graph is under construction produce no edge. The
// degree table holds no meaningful data after reset; draws are ignored until
// the first start transaction fills it, so no clearing pass runs after reset.
// Configuration may only be written while the block is idle.
module preferential_attachment_graph_builder #(
	parameter int MAX_NODES = pagb_pkg::MAX_NODES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [pagb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pagb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic [pagb_pkg::FRAC_W-1:0]          rand_fraction,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [pagb_pkg::NODE_OUT_W-1:0]      edge_source,
	output logic [pagb_pkg::NODE_OUT_W-1:0]      edge_target,
	output logic [pagb_pkg::EDGE_NUM_W-1:0]      edge_number,
	output logic                                 last_of_run,
	output logic                                 graph_done
);

	pagb_pkg::pagb_cmd_t    cmd;
	pagb_pkg::pagb_status_t status;

	// The controller sequences each transaction; the datapath owns the
	// degree table, the build counters and the output register.
	pagb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.status   (status),
		.cmd      (cmd)
	);

	pagb_dpath #(
		.MAX_NODES (MAX_NODES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rand_fraction (rand_fraction),
		.out_ready     (out_ready),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.edge_source   (edge_source),
		.edge_target   (edge_target),
		.edge_number   (edge_number),
		.last_of_run   (last_of_run),
		.graph_done    (graph_done)
	);

	// The edge that completes the graph is always the final edge of its transaction.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && graph_done |-> last_of_run)
		else $error("graph_done without last_of_run");

	// Every edge joins two distinct nodes (seed pairs and draws alike).
	a_no_self_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (MAX_NODES <= 1024) |-> edge_source != edge_target)
		else $error("self edge emitted");

	// A start transaction always runs the clearing sweep before the next one.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == pagb_pkg::OP_START) |=> !in_ready)
		else $error("input taken during table sweep");

	// After a non-last edge is taken, another edge is on offer or the block is busy.
	a_edge_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid || !in_ready)
		else $error("seed run ended without its last edge");

endmodule

>>> tb/tb.sv
module tb;

	// The block is built with its default table size, so the local copy of the
	// degree table uses the same depth.
	localparam int NODES        = pagb_pkg::MAX_NODES_DEF;
	// A degree-weighted draw on the largest node and the clearing sweep of a
	// start each walk up to the whole degree table, so this many quiet cycles after
	// the last expected edge mean the block has nothing left in flight.
	localparam int IDLE_WAIT    = NODES + 64;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 300;
	localparam int MAX_SHOWN    = 10;

	typedef struct packed {
		logic [pagb_pkg::NODE_OUT_W-1:0] src;
		logic [pagb_pkg::NODE_OUT_W-1:0] dst;
		logic [pagb_pkg::EDGE_NUM_W-1:0] num;
		logic                            last;
		logic                            done;
	} edge_rec_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_write;
	logic [pagb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pagb_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic                            op;
	logic [pagb_pkg::FRAC_W-1:0]     rand_fraction;
	logic                            out_valid;
	logic                            out_ready;
	logic [pagb_pkg::NODE_OUT_W-1:0] edge_source;
	logic [pagb_pkg::NODE_OUT_W-1:0] edge_target;
	logic [pagb_pkg::EDGE_NUM_W-1:0] edge_number;
	logic                            last_of_run;
	logic                            graph_done;

	preferential_attachment_graph_builder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.rand_fraction (rand_fraction),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.edge_source   (edge_source),
		.edge_target   (edge_target),
		.edge_number   (edge_number),
		.last_of_run   (last_of_run),
		.graph_done    (graph_done)
	);

	// Two-phase clock with a period of two time units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Local copy of the configuration registers, as the block last saw them.
	logic        mode_reg;
	logic [3:0]  seeds_reg;
	logic [10:0] nodes_reg;

	// Local copy of the graph under construction.
	logic [pagb_pkg::DEG_W-1:0] degree_of [NODES];
	int unsigned      grow_node;
	int unsigned      slot;
	int unsigned      edge_count;
	logic             growing;

	// Edges that the block still owes, oldest first.
	edge_rec_t edges_due[$];

	// Traffic shaping. A steady side never idles; the hold request makes the
	// result side refuse everything for a counted stretch of cycles.
	logic feed_steady = 1'b0;
	logic sink_steady = 1'b0;
	logic sink_hold   = 1'b0;
	int   hold_len    = 0;

	int unsigned fault_count   = 0;
	int unsigned edges_checked = 0;
	int unsigned starts_seen   = 0;
	int unsigned draws_seen    = 0;
	int unsigned useful_items  = 0;
	int unsigned reg_writes    = 0;
	int unsigned cycle_count   = 0;

	function automatic void queue_edge(input int unsigned src, input int unsigned dst,
		input logic last, input logic done);
		edges_due.push_back('{src[pagb_pkg::NODE_OUT_W-1:0], dst[pagb_pkg::NODE_OUT_W-1:0],
			edge_count[pagb_pkg::EDGE_NUM_W-1:0], last, done});
		edge_count = (edge_count + 1) & ((1 << pagb_pkg::EDGE_NUM_W) - 1);
	endfunction

	// Works out the edges that one accepted transaction causes and advances the
	// local copy of the graph.
	function automatic void grow_graph(input logic item_op,
		input logic [pagb_pkg::FRAC_W-1:0] frac);
		int unsigned     k, n, total, cnt, i, j, src, dst;
		longint unsigned x, prod, weight_sum, running;
		logic            fin;
		// Seed count saturates at eight, node count at the table depth.
		k = int'(seeds_reg);
		if (k > pagb_pkg::MAX_SEED) k = pagb_pkg::MAX_SEED;
		n = int'(nodes_reg);
		if (n > NODES) n = NODES;
		x = 64'(frac);
		if (item_op == pagb_pkg::OP_START) begin
			starts_seen++;
			useful_items++;
			foreach (degree_of[t]) degree_of[t] = (t < k) ? pagb_pkg::DEG_W'(1) : '0;
			grow_node  = k;
			slot       = 0;
			edge_count = 0;
			total      = k * (k - ((k != 0) ? 1 : 0));
			// A graph no larger than its seed is finished by the seed edges.
			fin        = (n <= k);
			growing    = (k != 0) && !fin;
			cnt        = 0;
			// Every seed pair is joined in both directions, the later node first.
			for (int a = 0; a + 1 < k; a++) begin
				for (int b = a + 1; b < k; b++) begin
					queue_edge(b, a, 1'b0, 1'b0);
					queue_edge(a, b, cnt + 2 == total, (cnt + 2 == total) && fin);
					cnt += 2;
				end
			end
			return;
		end
		draws_seen++;
		if (!growing) return;
		// Registers may have moved under a graph in progress; a finished count
		// ends the build quietly.
		if (k == 0 || grow_node >= n) begin
			growing = 1'b0;
			return;
		end
		useful_items++;
		i = grow_node;
		if (mode_reg) begin
			// Uniform pick: first t with x*i <= (t+1)*2^32.
			prod = (x * 64'(i) + 64'hFFFF_FFFF) >> 32;
			j    = (prod == 0) ? 0 : 32'(prod - 1);
		end else begin
			// Roulette pick: first t whose cumulative degree reaches x*S.
			weight_sum = 0;
			for (int t = 0; t < i; t++) weight_sum += 64'(degree_of[t]);
			prod    = x * weight_sum;
			j       = i - 1;
			running = 0;
			for (int t = 0; t < i; t++) begin
				running += 64'(degree_of[t]);
				if (prod <= (running << 32)) begin
					j = t;
					break;
				end
			end
		end
		// An even degree on the new node points the edge at it.
		if (degree_of[i][0] == 1'b0) begin
			src = j;
			dst = i;
		end else begin
			src = i;
			dst = j;
		end
		if (degree_of[i] != pagb_pkg::DEG_SAT) degree_of[i]++;
		if (degree_of[j] != pagb_pkg::DEG_SAT) degree_of[j]++;
		slot++;
		fin = 1'b0;
		if (slot >= k) begin
			slot = 0;
			grow_node++;
			if (grow_node >= n) begin
				growing = 1'b0;
				fin     = 1'b1;
			end
		end
		queue_edge(src, dst, 1'b1, fin);
	endfunction

	function automatic logic [pagb_pkg::FRAC_W-1:0] draw_fraction();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 255);
			3: return 32'hFFFF_FF00 | $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic note_fault(input string what, input edge_rec_t want, input edge_rec_t seen);
		fault_count++;
		if (fault_count <= MAX_SHOWN)
			$display("edge %0d %s: expected src=%0d dst=%0d num=%0d last=%0b done=%0b",
				edges_checked, what, want.src, want.dst, want.num, want.last, want.done);
		if (fault_count <= MAX_SHOWN)
			$display("    got src=%0d dst=%0d num=%0d last=%0b done=%0b",
				seen.src, seen.dst, seen.num, seen.last, seen.done);
	endtask

	// Register writes are only issued while the block is idle.
	task automatic write_reg(input logic [pagb_pkg::CFG_IDX_W-1:0] idx,
		input logic [pagb_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			pagb_pkg::CFG_ATTACH_MODE:    mode_reg  = value[0];
			pagb_pkg::CFG_EDGES_PER_NODE: seeds_reg = value[3:0];
			pagb_pkg::CFG_NODE_COUNT:     nodes_reg = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	// Writes all three registers. Unused upper data bits carry random junk,
	// which the block must ignore.
	task automatic configure(input logic mode, input logic [3:0] k, input logic [10:0] n);
		logic [pagb_pkg::CFG_DATA_W-1:0] junk;
		junk = $urandom_range(0, 2047);
		write_reg(pagb_pkg::CFG_ATTACH_MODE, {junk[10:1], mode});
		write_reg(pagb_pkg::CFG_EDGES_PER_NODE, {junk[10:4], k});
		write_reg(pagb_pkg::CFG_NODE_COUNT, n);
	endtask

	// Offers one transaction after a random gap and holds it until the block
	// takes it; the prediction is made at the accepting edge.
	task automatic send_item(input logic item_op, input logic [pagb_pkg::FRAC_W-1:0] frac);
		int gap;
		gap = feed_steady ? 0 : $urandom_range(0, 18);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		op            <= item_op;
		rand_fraction <= frac;
		do @(posedge clk); while (!in_ready);
		grow_graph(item_op, frac);
	endtask

	// Drops valid, waits for every owed edge and then lets the block run dry.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (edges_due.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	// Draws right after reset find no graph and must produce nothing.
	task automatic test_draws_before_start();
		send_item(pagb_pkg::OP_DRAW, '1);
		send_item(pagb_pkg::OP_DRAW, '0);
		wait_idle();
	endtask

	// Seed sizes of zero, one, eight and fifteen; fifteen saturates to eight.
	// A zero seed leaves no graph, so the draw after it is ignored, while the
	// draw after the saturated seed attaches node eight.
	task automatic test_seed_edges();
		configure(1'b0, 4'd0, 11'h7FF);
		send_item(pagb_pkg::OP_START, '0);
		send_item(pagb_pkg::OP_DRAW, 32'h8000_0000);
		wait_idle();
		configure(1'b1, 4'd1, 11'h7FF);
		send_item(pagb_pkg::OP_START, '1);
		wait_idle();
		configure(1'b0, 4'd8, 11'h7FF);
		send_item(pagb_pkg::OP_START, draw_fraction());
		wait_idle();
		configure(1'b0, 4'd15, 11'h7FF);
		send_item(pagb_pkg::OP_START, draw_fraction());
		send_item(pagb_pkg::OP_DRAW, '1);
		wait_idle();
	endtask

	// Node counts at or below the seed size finish on the last seed edge, and
	// any draw afterwards is ignored. A zero node count is the extreme case.
	task automatic test_seed_only_graph();
		configure(1'b0, 4'd3, 11'd3);
		send_item(pagb_pkg::OP_START, draw_fraction());
		send_item(pagb_pkg::OP_DRAW, draw_fraction());
		wait_idle();
		configure(1'b1, 4'd4, 11'd0);
		send_item(pagb_pkg::OP_START, draw_fraction());
		wait_idle();
	endtask

	// A complete weighted build with the fraction at its extremes and at one half,
	// followed by a draw on the finished graph.
	task automatic test_weighted_build();
		configure(1'b0, 4'd2, 11'd4);
		send_item(pagb_pkg::OP_START, '0);
		send_item(pagb_pkg::OP_DRAW, '0);
		send_item(pagb_pkg::OP_DRAW, '1);
		send_item(pagb_pkg::OP_DRAW, 32'h8000_0000);
		send_item(pagb_pkg::OP_DRAW, '1);
		send_item(pagb_pkg::OP_DRAW, '0);
		wait_idle();
	endtask

	// A complete uniform build with one edge per node, then a draw on the finished graph.
	task automatic test_uniform_build();
		configure(1'b1, 4'd1, 11'd3);
		send_item(pagb_pkg::OP_START, '0);
		send_item(pagb_pkg::OP_DRAW, '1);
		send_item(pagb_pkg::OP_DRAW, '0);
		send_item(pagb_pkg::OP_DRAW, '1);
		wait_idle();
	endtask

	// Registers rewritten while a graph is half built: a smaller edge count
	// moves on to the next node at once, and a node count already reached
	// ends the build without an edge.
	task automatic test_reconfig_mid_build();
		configure(1'b0, 4'd3, 11'h7FF);
		send_item(pagb_pkg::OP_START, draw_fraction());
		repeat (4) send_item(pagb_pkg::OP_DRAW, draw_fraction());
		wait_idle();
		write_reg(pagb_pkg::CFG_EDGES_PER_NODE, 11'd1);
		send_item(pagb_pkg::OP_DRAW, draw_fraction());
		wait_idle();
		write_reg(pagb_pkg::CFG_NODE_COUNT, 11'd5);
		send_item(pagb_pkg::OP_DRAW, draw_fraction());
		send_item(pagb_pkg::OP_DRAW, draw_fraction());
		wait_idle();
	endtask

	// Random graphs: mostly a start followed by enough draws to finish, with
	// random settings, stray draws before the start and restarts in the middle.
	task automatic test_random_graphs();
		int unsigned goal, k, n, kk, nn, need, budget, cut;
		goal = useful_items + RANDOM_ITEMS;
		while (useful_items < goal) begin
			wait_idle();
			feed_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
			case ($urandom_range(0, 9))
				0: n = $urandom_range(0, 1);
				1: n = ($urandom_range(0, 1) != 0) ? 2047 : 1024;
				2: n = $urandom_range(0, 2047);
				default: n = $urandom_range(2, 24);
			endcase
			configure(1'($urandom_range(0, 1)), 4'(k), 11'(n));
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3)) send_item(pagb_pkg::OP_DRAW, draw_fraction());
			send_item(pagb_pkg::OP_START, draw_fraction());
			// Large graphs are cut short so that the roulette scans stay short.
			kk     = (k > pagb_pkg::MAX_SEED) ? pagb_pkg::MAX_SEED : k;
			nn     = (n > NODES) ? NODES : n;
			need   = (kk != 0 && nn > kk) ? (nn - kk) * kk : 0;
			budget = ((need > 48) ? 48 : need) + $urandom_range(0, 2);
			cut    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, budget) : budget + 1;
			for (int d = 0; d < budget; d++)
				send_item((d == cut) ? pagb_pkg::OP_START : pagb_pkg::OP_DRAW,
					draw_fraction());
		end
		feed_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	// The result side stops for a long stretch while the input side keeps
	// offering draws back to back, so the seed edges back up and the block
	// stops taking input.
	task automatic test_output_stall();
		wait_idle();
		configure(1'b0, 4'd8, 11'd40);
		feed_steady = 1'b1;
		hold_len    = 1600;
		send_item(pagb_pkg::OP_START, draw_fraction());
		repeat (24) send_item(pagb_pkg::OP_DRAW, draw_fraction());
		feed_steady = 1'b0;
		wait_idle();
	endtask

	// Counts out a requested hold of the result side.
	initial begin : sink_holder
		forever begin
			wait (hold_len != 0);
			sink_hold = 1'b1;
			repeat (hold_len) @(posedge clk);
			sink_hold = 1'b0;
			hold_len  = 0;
		end
	end

	// Result side: a random stall before each edge, then ready stays
	// high until an edge is taken. Ready is only lowered when a stall follows,
	// so it never drops and rises within the same step.
	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = sink_steady ? 0 : $urandom_range(0, 18);
			if (stall != 0 || sink_hold) out_ready <= 1'b0;
			repeat (stall) @(negedge clk);
			while (sink_hold) @(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Every accepted edge is checked against the oldest owed edge.
	always @(posedge clk) begin : edge_check
		edge_rec_t seen, want;
		if (arst_n && out_valid && out_ready) begin
			seen = '{edge_source, edge_target, edge_number, last_of_run, graph_done};
			edges_checked++;
			if (edges_due.size() == 0) begin
				note_fault("arrived with none owed", '0, seen);
			end else begin
				want = edges_due.pop_front();
				if (seen !== want) note_fault("mismatch", want, seen);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d edges owed", cycle_count,
				edges_due.size());
			$display("** preferential_attachment_graph_builder: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = pagb_pkg::CFG_ATTACH_MODE;
		cfg_data      = '0;
		in_valid      = 1'b0;
		op            = pagb_pkg::OP_START;
		rand_fraction = '0;
		mode_reg      = pagb_pkg::ATTACH_MODE_RST;
		seeds_reg     = pagb_pkg::EDGES_PER_NODE_RST;
		nodes_reg     = pagb_pkg::NODE_COUNT_RST;
		grow_node     = 0;
		slot          = 0;
		edge_count    = 0;
		growing       = 1'b0;
		foreach (degree_of[t]) degree_of[t] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_draws_before_start();
		test_seed_edges();
		test_seed_only_graph();
		test_weighted_build();
		test_uniform_build();
		test_reconfig_mid_build();
		test_random_graphs();
		test_output_stall();
		wait_idle();

		$display("Sent %0d starts and %0d draws over %0d register writes; %0d edges checked.",
			starts_seen, draws_seen, reg_writes, edges_checked);
		$display("Seeds of 0 to 15 nodes, both pick modes, mid-build changes, a long output stall.");
		if (fault_count == 0 && edges_due.size() == 0) begin
			$display("** preferential_attachment_graph_builder: PASSED **");
		end else begin
			$display("%0d faults, %0d edges still owed", fault_count, edges_due.size());
			$display("** preferential_attachment_graph_builder: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/pagb_pkg.sv
rtl/pagb_ctrl.sv
rtl/pagb_dpath.sv
rtl/preferential_attachment_graph_builder.sv
tb/tb.sv
